// File: hdl/crpt_pkg.sv
package crpt_pkg;

  localparam int MaxPlanes = 16;
  localparam int IdxW = $clog2(MaxPlanes);
  localparam int CntW = $clog2(MaxPlanes + 1);
  localparam logic [30:0] ThreshReset = 31'd1073634450;

  typedef struct packed {
    logic               func;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic       inside_res;
    logic       merged;
    logic       table_full;
    logic       bad_normal;
    logic [4:0] plane_count;
  } out_item_t;

  typedef enum logic [1:0] {
    DP_LEN  = 2'd0,
    DP_NORM = 2'd1,
    DP_PDOT = 2'd2,
    DP_NDOT = 2'd3
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       start;
    dp_op_t     op;
    logic [1:0] comp;
    logic [IdxW-1:0] idx;
    logic       write_plane;
    logic       write_offset;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic zero_len;
    logic gt_offset;
    logic parallel;
    logic newd_gt;
  } dp_sts_t;

endpackage

// File: hdl/crpt_datapath.sv
module crpt_datapath (
  input  logic                clk,
  input  crpt_pkg::in_item_t  item,
  input  crpt_pkg::dp_cmd_t   cmd,
  input  logic [30:0]         thresh,
  output crpt_pkg::dp_sts_t   sts
);
  import crpt_pkg::*;

  logic signed [15:0] nrm_mem [MaxPlanes][3];
  logic signed [51:0] off_mem [MaxPlanes];

  in_item_t           item_r;
  logic [32:0]        len2_r;
  logic signed [15:0] unit_r [3];
  logic signed [15:0] nrm_rd_r [3];
  logic signed [51:0] off_rd_r;
  logic signed [51:0] acc_r;
  logic signed [51:0] newd_r;
  logic [1:0]         step_r;
  logic               busy_r;
  logic [14:0]        lo_r, hi_r;
  logic [4:0]         bits_r;

  logic signed [15:0] rawc;
  logic [15:0]        absc;
  logic signed [15:0] sn;
  logic signed [31:0] sp;
  logic signed [47:0] prod;
  logic [14:0]        mid;
  logic [15:0]        dd;
  logic [31:0]        dsq_r;
  logic [64:0]        lhs;
  logic [62:0]        target;
  logic               phase_r;

  always_comb begin
    case (cmd.comp)
      2'd0:    rawc = item_r.norm_x;
      2'd1:    rawc = item_r.norm_y;
      default: rawc = item_r.norm_z;
    endcase
    absc = rawc[15] ? 16'(-rawc) : rawc;
    sn = 16'sd0;
    sp = 32'sd0;
    case (step_r)
      2'd0: begin
        sp = item_r.pos_x;
      end
      2'd1: begin
        sp = item_r.pos_y;
      end
      default: begin
        sp = item_r.pos_z;
      end
    endcase
    case (cmd.op)
      DP_LEN: begin
        sn = (step_r == 2'd0) ? item_r.norm_x : (step_r == 2'd1) ? item_r.norm_y
                                                                 : item_r.norm_z;
        sp = 32'(sn);
      end
      DP_NORM: sn = unit_r[step_r];
      DP_PDOT: sn = nrm_rd_r[step_r];
      DP_NDOT: begin
        sn = nrm_rd_r[step_r];
        sp = 32'(unit_r[step_r]);
      end
      default: sn = 16'sd0;
    endcase
    prod = sn * sp;
    mid = 15'((16'(lo_r) + 16'(hi_r) + 16'd1) >> 1);
    dd = {mid, 1'b0} - 16'd1;
    lhs = 65'(dsq_r) * 65'(len2_r);
    target = {31'(absc) * 31'(absc), 32'd0} >> 2;
  end

  // dot products take one term per cycle; sqrt search squares a trial root, then compares and narrows the range
  // table row at cmd.idx is registered, so it is ready after the start cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
      busy_r <= 1'b0;
    end else if (cmd.start) begin
      busy_r  <= 1'b1;
      step_r  <= 2'd0;
      acc_r   <= '0;
      lo_r    <= '0;
      hi_r    <= 15'd16384;
      bits_r  <= 5'd0;
      phase_r <= 1'b0;
    end else if (busy_r) begin
      // comp 3 under DP_NORM is the new offset: unit normal dot point
      if (cmd.op == DP_LEN || cmd.op == DP_PDOT || cmd.op == DP_NDOT ||
          (cmd.op == DP_NORM && cmd.comp == 2'd3)) begin
        acc_r  <= acc_r + 52'(prod);
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          if (cmd.op == DP_LEN) len2_r <= 33'(acc_r + 52'(prod));
        end
      end else begin
        if (!phase_r) begin
          dsq_r   <= 32'(dd) * 32'(dd);
          phase_r <= 1'b1;
        end else begin
          phase_r <= 1'b0;
          if (lhs <= 65'(target)) lo_r <= mid;
          else hi_r <= mid - 15'd1;
          bits_r <= bits_r + 5'd1;
          if (bits_r == 5'd15) begin
            busy_r <= 1'b0;
            unit_r[cmd.comp] <= rawc[15] ? -16'(lo_r) : 16'(lo_r);
          end
        end
      end
    end
    nrm_rd_r[0] <= nrm_mem[cmd.idx][0];
    nrm_rd_r[1] <= nrm_mem[cmd.idx][1];
    nrm_rd_r[2] <= nrm_mem[cmd.idx][2];
    off_rd_r    <= off_mem[cmd.idx];
    if (cmd.write_plane) begin
      nrm_mem[cmd.idx][0] <= unit_r[0];
      nrm_mem[cmd.idx][1] <= unit_r[1];
      nrm_mem[cmd.idx][2] <= unit_r[2];
      off_mem[cmd.idx]    <= newd_r;
    end
    if (cmd.write_offset) off_mem[cmd.idx] <= acc_r;
    if (cmd.op == DP_PDOT && cmd.comp == 2'd3 && !busy_r) newd_r <= acc_r;
  end

  always_comb begin
    sts.done      = !busy_r && !cmd.start && !cmd.load;
    sts.zero_len  = (len2_r == '0);
    sts.gt_offset = acc_r > off_rd_r;
    sts.parallel  = (acc_r <<< 2) >= $signed({21'd0, thresh});
    sts.newd_gt   = newd_r > off_rd_r;
  end

endmodule

// File: hdl/crpt_ctrl.sv
module crpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  output logic                out_valid,
  input  logic                out_stall,
  output crpt_pkg::out_item_t out_data,
  output crpt_pkg::dp_cmd_t   cmd,
  input  crpt_pkg::dp_sts_t   sts
);
  import crpt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LEN   = 9'b000000010,
    S_NORM  = 9'b000000100,
    S_NEWD  = 9'b000001000,
    S_NDOT  = 9'b000010000,
    S_MDOT  = 9'b000100000,
    S_TDOT  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            started_r, started_nxt;
  logic [1:0]      comp_r, comp_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            ovalid_r, ovalid_nxt;
  out_item_t       res_r, res_nxt;
  logic            last;

  assign last      = (32'(idx_r) + 32'd1 >= 32'(count_r));
  assign in_stall  = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    comp_nxt    = comp_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    ovalid_nxt  = ovalid_r && out_stall;
    res_nxt     = res_r;
    cmd         = '0;
    cmd.idx     = idx_r;
    cmd.comp    = comp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load    = 1'b1;
          started_nxt = 1'b0;
          idx_nxt     = '0;
          comp_nxt    = 2'd0;
          res_nxt     = '0;
          if (in_func) state_nxt = (count_r == '0) ? S_DONE : S_TDOT;
          else state_nxt = S_LEN;
          if (in_func) res_nxt.inside_res = 1'b1;
        end
      end
      S_LEN: begin
        cmd.op = DP_LEN;
        if (!started_r) begin
          cmd.start = 1'b1; started_nxt = 1'b1;
        end else if (sts.done) begin
          started_nxt = 1'b0;
          if (sts.zero_len) begin
            res_nxt.bad_normal = 1'b1; state_nxt = S_DONE;
          end else state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        cmd.op = DP_NORM;
        if (!started_r) begin
          cmd.start = 1'b1; started_nxt = 1'b1;
        end else if (sts.done) begin
          started_nxt = 1'b0;
          comp_nxt = comp_r + 2'd1;
          if (comp_r == 2'd2) state_nxt = S_NEWD;
        end
      end
      S_NEWD: begin
        cmd.op = DP_NORM;
        cmd.comp = 2'd3;
        if (!started_r) begin
          cmd.start = 1'b1; started_nxt = 1'b1;
        end else if (sts.done) begin
          cmd.op = DP_PDOT;
          started_nxt = 1'b0;
          state_nxt = (count_r == '0) ? S_WRITE : S_NDOT;
        end
      end
      S_NDOT: begin
        cmd.op = DP_NDOT;
        if (!started_r) begin
          cmd.start = 1'b1; started_nxt = 1'b1;
        end else if (sts.done) begin
          started_nxt = 1'b0;
          if (sts.parallel) begin
            res_nxt.merged = 1'b1;
            state_nxt = sts.newd_gt ? S_MDOT : S_DONE;
          end else if (last) state_nxt = S_WRITE;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_MDOT: begin
        cmd.op = DP_PDOT;
        if (!started_r) begin
          cmd.start = 1'b1; started_nxt = 1'b1;
        end else if (sts.done) begin
          cmd.write_offset = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_TDOT: begin
        cmd.op = DP_PDOT;
        if (!started_r) begin
          cmd.start = 1'b1; started_nxt = 1'b1;
        end else if (sts.done) begin
          started_nxt = 1'b0;
          if (sts.gt_offset) begin
            res_nxt.inside_res = 1'b0; state_nxt = S_DONE;
          end else if (last) state_nxt = S_DONE;
          else idx_nxt = idx_r + 1'b1;
        end
      end
      S_WRITE: begin
        if (32'(count_r) >= MaxPlanes) res_nxt.table_full = 1'b1;
        else begin
          cmd.idx = count_r[IdxW-1:0];
          cmd.write_plane = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!(ovalid_r && out_stall)) begin
          ovalid_nxt = 1'b1;
          res_nxt.plane_count = 5'(count_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
      started_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      started_r <= started_nxt;
    end
    comp_r <= comp_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

endmodule

// File: hdl/convex_region_point_test.sv
// test: one dot product per stored plane checked, stopping at the first outside
// add: length, three 16-step square-root searches, new offset, write and result,
// plus one normal dot product per plane compared
// throughput: one item at a time; next transfer accepted with the result transfer
// reset: synchronous active low, clears plane count and output valid, loads
// the default threshold; plane table contents are undefined until written
module convex_region_point_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crpt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crpt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [30:0]         cfg_data
);
  import crpt_pkg::*;

  logic [30:0] thresh_r;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) thresh_r <= ThreshReset;
    else if (cfg_valid) thresh_r <= cfg_data;
  end

  crpt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_func(in_data.func),
    .out_valid, .out_stall, .out_data, .cmd, .sts
  );

  crpt_datapath u_dp (.clk, .item(in_data), .cmd, .thresh(thresh_r), .sts);

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.plane_count <= 5'(MaxPlanes))
    else $error("plane count overflow");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.inside_res, out_data.merged,
                              out_data.table_full, out_data.bad_normal}) <= 1)
    else $error("conflicting result flags");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

// File: test/crpt_checker.sv
module crpt_checker
  import crpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [30:0] cfg_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [15:0] unit_nrm [MaxPlanes][3];
  logic signed [63:0] plane_ofs [MaxPlanes];
  int unsigned        plane_num;
  logic [30:0]        par_thresh;
  out_item_t          expected_q[$];

  assign pending = expected_q.size();

  // nearest q1.14 unit component, ties away from zero
  function automatic logic signed [15:0] unit_component(logic signed [15:0] c,
                                                        longint unsigned len2);
    longint unsigned mag, target, lo, hi, mid, d;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    target = (mag * mag) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * len2 <= target) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -16'(lo) : 16'(lo);
  endfunction

  function automatic logic signed [63:0] dot3(logic signed [63:0] a0, logic signed [63:0] a1,
                                              logic signed [63:0] a2, logic signed [63:0] b0,
                                              logic signed [63:0] b1, logic signed [63:0] b2);
    return a0 * b0 + a1 * b1 + a2 * b2;
  endfunction

  function automatic out_item_t region_update(in_item_t it);
    out_item_t r;
    logic signed [15:0] u [3];
    logic signed [63:0] nd, newd;
    longint unsigned len2;
    bit done;
    r = '0;
    done = 0;
    if (it.func) begin
      r.inside_res = 1'b1;
      for (int i = 0; i < plane_num; i++) begin
        if (dot3(unit_nrm[i][0], unit_nrm[i][1], unit_nrm[i][2],
                 it.pos_x, it.pos_y, it.pos_z) > plane_ofs[i]) begin
          r.inside_res = 1'b0;
          break;
        end
      end
    end else begin
      len2 = longint'(it.norm_x) * it.norm_x + longint'(it.norm_y) * it.norm_y +
             longint'(it.norm_z) * it.norm_z;
      if (len2 == 0) begin
        r.bad_normal = 1'b1;
      end else begin
        u[0] = unit_component(it.norm_x, len2);
        u[1] = unit_component(it.norm_y, len2);
        u[2] = unit_component(it.norm_z, len2);
        for (int i = 0; i < plane_num; i++) begin
          nd = dot3(unit_nrm[i][0], unit_nrm[i][1], unit_nrm[i][2], u[0], u[1], u[2]) * 4;
          if (nd >= $signed({33'd0, par_thresh})) begin
            newd = dot3(u[0], u[1], u[2], it.pos_x, it.pos_y, it.pos_z);
            if (newd > plane_ofs[i])
              plane_ofs[i] = dot3(unit_nrm[i][0], unit_nrm[i][1], unit_nrm[i][2],
                                  it.pos_x, it.pos_y, it.pos_z);
            r.merged = 1'b1;
            done = 1;
            break;
          end
        end
        if (!done) begin
          if (plane_num >= MaxPlanes) begin
            r.table_full = 1'b1;
          end else begin
            for (int k = 0; k < 3; k++) unit_nrm[plane_num][k] = u[k];
            plane_ofs[plane_num] = dot3(u[0], u[1], u[2], it.pos_x, it.pos_y, it.pos_z);
            plane_num++;
          end
        end
      end
    end
    r.plane_count = 5'(plane_num);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      plane_num = 0;
      par_thresh = ThreshReset;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) par_thresh = cfg_data;
      if (in_valid && !in_stall) expected_q.push_back(region_update(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_data !== e) begin
            if (out_data.inside_res !== e.inside_res)
              $error("inside_res exp %0d got %0d", e.inside_res, out_data.inside_res);
            if (out_data.merged !== e.merged)
              $error("merged exp %0d got %0d", e.merged, out_data.merged);
            if (out_data.table_full !== e.table_full)
              $error("table_full exp %0d got %0d", e.table_full, out_data.table_full);
            if (out_data.bad_normal !== e.bad_normal)
              $error("bad_normal exp %0d got %0d", e.bad_normal, out_data.bad_normal);
            if (out_data.plane_count !== e.plane_count)
              $error("plane_count exp %0d got %0d", e.plane_count, out_data.plane_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: test/testbench.sv
module testbench;
  import crpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [30:0] cfg_data;
  int        fail_count;
  int        pending;
  int        idle_cycles;
  bit        hold_off;

  convex_region_point_test u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  crpt_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // receiver: random stall per transfer, one long hold-off on request
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk iff !in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_thresh(logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(0, 4))
      0: return 16'sd0;
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'($urandom);
      default: return 32'($signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000);
    endcase
  endfunction

  function automatic in_item_t rnd_item(bit add);
    in_item_t it;
    it.func = ~add;
    it.norm_x = rnd_comp();
    it.norm_y = rnd_comp();
    it.norm_z = rnd_comp();
    it.pos_x = rnd_pos();
    it.pos_y = rnd_pos();
    it.pos_z = rnd_pos();
    return it;
  endfunction

  function automatic in_item_t mk(bit f, int nx, int ny, int nz, int px, int py, int pz);
    in_item_t it;
    it.func = f;
    it.norm_x = 16'(nx);
    it.norm_y = 16'(ny);
    it.norm_z = 16'(nz);
    it.pos_x = 32'(px);
    it.pos_y = 32'(py);
    it.pos_z = 32'(pz);
    return it;
  endfunction

  initial begin
    logic [30:0] thr_set [4];
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_off = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, zero normal, box, merges, fill, extremes
    send_item(mk(1, 0, 0, 0, 0, 0, 0));
    send_item(mk(0, 0, 0, 0, 5, 5, 5));
    send_item(mk(0, 1, 0, 0, 32'h10000, 0, 0));
    send_item(mk(0, -1, 0, 0, -32'h10000, 0, 0));
    send_item(mk(0, 0, 300, 0, 0, 32'h20000, 0));
    send_item(mk(0, 5, 0, 0, 32'h30000, 0, 0));
    send_item(mk(0, 7, 0, 0, 32'h8000, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 32'h30000, 0, 0));
    send_item(mk(1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_item(mk(0, -32768, -32768, -32768, 32'h80000000, 32'h80000000, 32'h80000000));
    send_item(mk(0, 32767, 32767, 32767, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_item(mk(0, 1, 1, 0, 0, 0, 0));
    send_item(mk(0, 3, -4, 12, 100, -200, 300));
    for (int i = 0; i < 10; i++) send_item(rnd_item(1));
    send_item(mk(1, 0, 0, 0, 0, 0, 0));
    drain();

    // threshold settings including both extremes and above one
    thr_set[0] = 31'd0;
    thr_set[1] = 31'd1073741824;
    thr_set[2] = 31'h7fffffff;
    thr_set[3] = 31'd900000000;
    for (int ph = 0; ph < 8; ph++) begin
      write_thresh((ph < 4) ? thr_set[ph] : 31'($urandom_range(700000000, 1073741824)));
      if (ph == 2) hold_off = 1;
      for (int n = 0; n < 160; n++) begin
        it = rnd_item($urandom_range(0, 2) == 0);
        send_item(it);
      end
      drain();
    end

    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
